// ===== rtl/core/rotary_knob_decoder_with_event_queue_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the rotary knob decoder
// Shorthand for clocked properties, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef ROTARY_KNOB_DECODER_WITH_EVENT_QUEUE_ASSERT_SVH
`define ROTARY_KNOB_DECODER_WITH_EVENT_QUEUE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define RKD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define RKD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rkd_pkg.sv =====
// ----------------------------------------------------------------------------
// rkd_pkg
// Shared codes, types and defaults of the rotary knob decoder.
// ----------------------------------------------------------------------------
package rkd_pkg;

  // Input action codes
  localparam logic [1:0] ACT_A_CHANGE = 2'd0;
  localparam logic [1:0] ACT_B_CHANGE = 2'd1;
  localparam logic [1:0] ACT_POLL     = 2'd2;

  // Event codes
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_RANGE_UP = 3'd1;
  localparam logic [2:0] EV_RANGE_DN = 3'd2;
  localparam logic [2:0] EV_MODE_UP  = 3'd3;
  localparam logic [2:0] EV_MODE_DN  = 3'd4;

  localparam int DEFAULT_QUEUE_DEPTH = 8;

  // Event request from the decoder to the queue
  typedef struct packed {
    logic       valid;
    logic [2:0] code;
  } push_t;

endpackage

// ===== rtl/core/rkd_quad_fsm.sv =====
// ----------------------------------------------------------------------------
// rkd_quad_fsm
// Quadrature state machine: tracks the closing order of contacts A and B and
// raises one event per detent, coded by direction and the push contact.
// ----------------------------------------------------------------------------
module rkd_quad_fsm (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  logic [1:0]    action,
  input  logic          a_open,
  input  logic          b_open,
  input  logic          c_open,
  output rkd_pkg::push_t push
);
  import rkd_pkg::*;

  typedef enum logic [2:0] {
    ST_START   = 3'd0,
    ST_AFIRST  = 3'd1,
    ST_BSECOND = 3'd2,
    ST_BFIRST  = 3'd3,
    ST_ASECOND = 3'd4
  } state_t;

  state_t state_r, state_nxt;

  // Next state and detent event
  always_comb begin
    state_nxt  = state_r;
    push.valid = 1'b0;
    push.code  = EV_NONE;
    case (action)
      ACT_A_CHANGE: begin
        if (!a_open) begin
          if (state_r == ST_START) begin
            state_nxt = ST_AFIRST;
          end else if (state_r == ST_BFIRST) begin
            state_nxt  = ST_ASECOND;
            push.valid = step_en;
            push.code  = c_open ? EV_RANGE_DN : EV_MODE_UP;
          end
        end else if (b_open) begin
          state_nxt = ST_START;
        end
      end
      ACT_B_CHANGE: begin
        if (!b_open) begin
          if (state_r == ST_START) begin
            state_nxt = ST_BFIRST;
          end else if (state_r == ST_AFIRST) begin
            state_nxt  = ST_BSECOND;
            push.valid = step_en;
            push.code  = c_open ? EV_RANGE_UP : EV_MODE_DN;
          end
        end else if (a_open) begin
          state_nxt = ST_START;
        end
      end
      default: begin
        state_nxt = state_r;
      end
    endcase
  end

  // State register, moves only on a transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
    end else if (step_en) begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/rotary_knob_decoder_with_event_queue.sv =====
// ----------------------------------------------------------------------------
// rotary_knob_decoder_with_event_queue
// Takes one item per cycle: a change on contact A or B, or a poll. Detents
// are decoded into range/mode up/down events and kept in a ring queue held
// in a single-port-write, registered-read memory of QUEUE_DEPTH entries; the
// queue holds at most QUEUE_DEPTH-1 events and drops new ones when full.
// Every poll yields one result, the oldest event or none, which passes
// through the read stage (memory read) and then the output register.
// Contact changes yield no result. The sustained rate is one item per cycle
// while results are taken; a stalled result stops input only once both the
// read stage and the output register are occupied.
// ----------------------------------------------------------------------------
`include "rotary_knob_decoder_with_event_queue_assert.svh"

module rotary_knob_decoder_with_event_queue #(
  parameter int QUEUE_DEPTH = rkd_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic       in_a_open,
  input  logic       in_b_open,
  input  logic       in_c_open,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_event_code
);
  import rkd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

  logic             in_xfer;
  logic             poll;
  push_t            push;
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W-1:0] wr_ptr_inc, rd_ptr_inc;
  logic             q_empty, q_full;
  logic             wr_en, rd_en;
  logic [2:0]       event_mem_r [QUEUE_DEPTH];
  logic [2:0]       mem_q_r;
  logic             s1_valid_r, s1_hit_r;
  logic             s1_adv;
  logic             out_valid_r;
  logic [2:0]       out_code_r;

  // Input transfer
  assign in_xfer = in_valid && in_ready;
  assign poll    = in_xfer && (in_action == ACT_POLL);
  assign s1_adv  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  // Detent decoder
  rkd_quad_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_xfer),
    .action  (in_action),
    .a_open  (in_a_open),
    .b_open  (in_b_open),
    .c_open  (in_c_open),
    .push    (push)
  );

  // Ring pointers
  assign wr_ptr_inc = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_inc = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
  assign q_empty    = (rd_ptr_r == wr_ptr_r);
  assign q_full     = (wr_ptr_inc == rd_ptr_r);
  assign wr_en      = push.valid && !q_full;
  assign rd_en      = poll && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_inc;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_inc;
      end
    end
  end

  // Event memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      event_mem_r[wr_ptr_r] <= push.code;
    end
    if (rd_en) begin
      mem_q_r <= event_mem_r[rd_ptr_r];
    end
  end

  // Read stage: a poll waits here for its memory data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_hit_r   <= 1'b0;
    end else if (poll) begin
      s1_valid_r <= 1'b1;
      s1_hit_r   <= !q_empty;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_code_r  <= EV_NONE;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
      out_code_r  <= s1_hit_r ? mem_q_r : EV_NONE;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_code = out_code_r;

  // Checks
  `RKD_ASSERT_SAME(a_no_push_pop, 1'b1, !(wr_en && rd_en), "push and pop in one transfer")
  `RKD_ASSERT_NEXT(a_pop_hits, rd_en, s1_valid_r && s1_hit_r, "pop did not reach read stage")
  `RKD_ASSERT_SAME(a_stall_cause, !in_ready, s1_valid_r && out_valid_r && !out_ready, "bad stall")

endmodule
